// ===== rtl/text_console_writer_assert.svh =====
// Assertion macros shared by the console writer RTL.
// Every user must have clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw: next-cycle check failed");

`endif

// ===== rtl/tcw_pkg.sv =====
// Types and constants of the text console writer.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
    localparam logic [1:0] OP_CLEAR      = 2'd1;
    localparam logic [1:0] OP_SET_CURSOR = 2'd2;
    localparam logic [1:0] OP_READ_CELL  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // command beat
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
        logic [4:0] target_row;
        logic [6:0] target_col;
    } tcw_in_t;

    // response beat
    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } tcw_rsp_t;

    // decoded operation handed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic       nl;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
    } tcw_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tcw_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// Command front end: accepts beats, clamps targets, builds attributes.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire tcw_in_t    cmd,
    input  wire tcw_qstat_t q_stat,
    input  wire logic       init_busy,
    output logic            push,
    output tcw_op_t         push_data
);

    logic [7:0] put_attr;
    logic [7:0] clr_attr;

    assign cmd_stall = q_stat.full || init_busy;
    assign push      = cmd_valid && !cmd_stall;

    assign put_attr = {1'b0, cmd.bg_color[2:0], cmd.fg_color};
    assign clr_attr = {1'b0, cmd.bg_color[2:0], 4'b0000};

    always_comb
    begin
        push_data.op   = cmd.opcode;
        push_data.nl   = (cmd.char_code == CHAR_NEWLINE);
        push_data.ch   = cmd.char_code;
        push_data.attr = (cmd.opcode == OP_CLEAR) ? clr_attr : put_attr;
        // clamped value never exceeds the raw one, so the narrow casts are safe
        push_data.row  = (int'(cmd.target_row) > ROWS - 1) ? 5'(ROWS - 1) : cmd.target_row;
        push_data.col  = (int'(cmd.target_col) > COLS - 1) ? 7'(COLS - 1) : cmd.target_col;
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_queue.sv =====
// Two-entry queue of decoded operations between front and back.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire tcw_op_t push_data,
    input  wire logic    pop,
    output tcw_op_t      head,
    output tcw_qstat_t   q_stat
);

    tcw_op_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    `TCW_ASSERT_SAME(a_no_push_full, push, !q_stat.full)
    `TCW_ASSERT_SAME(a_no_pop_empty, pop, !q_stat.empty)

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
// Execution engine: cursor, cell buffer, scroll/clear sweeps, response register.
// Depends on tcw_pkg, tcw_ram and text_console_writer_assert.svh.
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tcw_qstat_t q_stat,
    input  wire tcw_op_t    head,
    output logic            pop,
    output logic            init_busy,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output tcw_rsp_t        rsp
);

    localparam int N         = ROWS * COLS;
    localparam int AW        = $clog2(N);
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLS);
    localparam int LAST_BASE = (ROWS - 1) * COLS;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDONE = 3'd2;
    localparam logic [2:0] S_CLR   = 3'd3;
    localparam logic [2:0] S_SCRL  = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_PUTW  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    tcw_op_t       op_reg, op_next;
    tcw_rsp_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          slot_free;
    logic          dispatch;
    logic          rsp_load;
    logic          head_scroll;
    logic          cnt_last;
    logic          advance;
    logic [RW-1:0] nrow;
    logic [CW-1:0] ncol;
    logic [RW-1:0] mul_row;
    logic [CW-1:0] mul_col;
    logic [AW-1:0] cell_addr;

    logic          re;
    logic [AW-1:0] raddr;
    logic          char_we;
    logic          attr_we;
    logic [AW-1:0] waddr;
    logic [7:0]    wchar;
    logic [7:0]    wattr;
    logic [7:0]    char_rdata;
    logic [7:0]    attr_rdata;

    tcw_ram #(.WIDTH(8), .DEPTH(N)) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (waddr),
        .wdata (wchar),
        .re    (re),
        .raddr (raddr),
        .rdata (char_rdata)
    );

    tcw_ram #(.WIDTH(8), .DEPTH(N)) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (waddr),
        .wdata (wattr),
        .re    (re),
        .raddr (raddr),
        .rdata (attr_rdata)
    );

    assign slot_free   = !rsp_valid_reg || !rsp_stall;
    assign dispatch    = (state_reg == S_IDLE) && !q_stat.empty && slot_free;
    assign pop         = dispatch;
    assign init_busy   = (state_reg == S_INIT);
    assign cnt_last    = (cnt_reg == AW'(N - 1));
    assign head_scroll = (row_reg == RW'(ROWS - 1)) && (head.nl || col_reg == CW'(COLS - 1));

    // one shared row*COLS+col address generator
    assign cell_addr = AW'(mul_row) * AW'(COLS) + AW'(mul_col);

    // put char: cursor after the column-0 check (char_rdata holds that cell)
    always_comb
    begin
        advance = !op_reg.nl && (col_reg != '0 || char_rdata != 8'd0);
        nrow    = row_reg;
        ncol    = col_reg;
        if (op_reg.nl)
        begin
            nrow = row_reg + 1'b1;
            ncol = '0;
        end
        else if (advance)
        begin
            if (col_reg == CW'(COLS - 1))
            begin
                nrow = row_reg + 1'b1;
                ncol = '0;
            end
            else
            begin
                ncol = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        op_next    = op_reg;
        rsp_next   = rsp_reg;
        rsp_load   = 1'b0;
        mul_row    = row_reg;
        mul_col    = '0;
        re         = 1'b0;
        raddr      = cell_addr;
        char_we    = 1'b0;
        attr_we    = 1'b0;
        waddr      = cnt_reg;
        wchar      = 8'd0;
        wattr      = 8'd0;

        case (state_reg)
            S_INIT:
            begin
                char_we  = 1'b1;
                attr_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (dispatch)
                begin
                    op_next = head;
                    case (head.op)
                        OP_PUT_CHAR:
                        begin
                            re = 1'b1;
                            if (head_scroll)
                            begin
                                raddr      = AW'(COLS);
                                cnt_next   = '0;
                                state_next = S_SCRL;
                            end
                            else
                            begin
                                state_next = S_PUTW;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_SET_CURSOR:
                        begin
                            row_next            = RW'(head.row);
                            col_next            = CW'(head.col);
                            rsp_next.cursor_row = head.row;
                            rsp_next.cursor_col = head.col;
                            rsp_next.cell_char  = 8'd0;
                            rsp_next.cell_attr  = 8'd0;
                            rsp_load            = 1'b1;
                        end
                        OP_READ_CELL:
                        begin
                            mul_row    = RW'(head.row);
                            mul_col    = CW'(head.col);
                            re         = 1'b1;
                            state_next = S_RDONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RDONE:
            begin
                rsp_next.cursor_row = 5'(row_reg);
                rsp_next.cursor_col = 7'(col_reg);
                rsp_next.cell_char  = char_rdata;
                rsp_next.cell_attr  = attr_rdata;
                rsp_load            = 1'b1;
                state_next          = S_IDLE;
            end

            S_CLR:
            begin
                char_we  = 1'b1;
                attr_we  = 1'b1;
                wattr    = op_reg.attr;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next            = '0;
                    row_next            = '0;
                    col_next            = '0;
                    rsp_next.cursor_row = 5'd0;
                    rsp_next.cursor_col = 7'd0;
                    rsp_next.cell_char  = 8'd0;
                    rsp_next.cell_attr  = 8'd0;
                    rsp_load            = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_SCRL:
            begin
                // write cell cnt from the read issued last cycle; bottom row gets zeros
                char_we  = 1'b1;
                attr_we  = 1'b1;
                if (cnt_reg < AW'(LAST_BASE))
                begin
                    wchar = char_rdata;
                    wattr = attr_rdata;
                end
                if (cnt_reg < AW'(LAST_BASE - 1))
                begin
                    re    = 1'b1;
                    raddr = cnt_reg + AW'(COLS + 1);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    row_next   = row_reg - 1'b1;
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                re         = 1'b1;
                state_next = S_PUTW;
            end

            S_PUTW:
            begin
                mul_row             = nrow;
                mul_col             = ncol;
                waddr               = cell_addr;
                attr_we             = 1'b1;
                char_we             = !op_reg.nl;
                wchar               = op_reg.ch;
                wattr               = op_reg.attr;
                row_next            = nrow;
                col_next            = ncol;
                rsp_next.cursor_row = 5'(nrow);
                rsp_next.cursor_col = 7'(ncol);
                rsp_next.cell_char  = 8'd0;
                rsp_next.cell_attr  = 8'd0;
                rsp_load            = 1'b1;
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = (rsp_valid_reg && rsp_stall) || rsp_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TCW_ASSERT_SAME(a_pop_needs_slot, pop, slot_free)
    `TCW_ASSERT_SAME(a_no_overwrite, rsp_valid_reg && rsp_stall, !rsp_load)
    `TCW_ASSERT_NEXT(a_read_completes, state_reg == S_RDONE, rsp_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: front end, operation queue, engine.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//  channel | beat type | handshake            | role
//  cmd     | tcw_in_t  | cmd_valid, cmd_stall | operation in
//  rsp     | tcw_rsp_t | rsp_valid, rsp_stall | cursor and read data out, one per cmd
//
// Set cursor is done at dispatch; read cell adds S_RDONE; put char adds S_PUTW,
// preceded by an S_SCRL sweep and S_CHK on scroll; clear screen is an S_CLR sweep.
// After reset a clearing pass over all ROWS*COLS cells zeroes the buffer; cmd is stalled.
// cmd stalls when the two-entry queue is full; the engine waits on a held rsp beat.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire tcw_in_t  cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output tcw_rsp_t      rsp
);

    tcw_qstat_t q_stat;
    tcw_op_t    push_data;
    tcw_op_t    head;
    logic       push;
    logic       pop;
    logic       init_busy;

    tcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .init_busy (init_busy),
        .push      (push),
        .push_data (push_data)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    tcw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
